// ----- hdl/polyphonic_voice_allocator_assert.svh -----
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pva_pkg.sv -----
`timescale 1ns / 1ps
package pva_pkg;

  localparam int TAG_W     = 32;
  localparam int INTENS_W  = 16;
  localparam int VOICE_W   = 5;
  localparam int MASK_W    = 32;
  localparam int NV_W      = 6;
  localparam int ACT_W     = 2;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DONE     = 2'd2;

  // register select is the word address bit
  localparam logic REG_VOICES = 1'b0;
  localparam logic REG_RETRIG = 1'b1;

  typedef struct packed {
    logic tag_eq;
    logic hit;
    logic older;
  } scan_flags_t;

endpackage

// ----- hdl/polyphonic_voice_allocator.sv -----
// note-on and note-off walk the tag/age ram one voice per cycle via its registered read,
//   then pass the finish and emit states to the registered result
// voice-done, unknown actions and events with no voices in use skip the walk and go to emit
// inputs are taken only in idle; a waiting result does not block the next input
// reset (rst_n, synchronous): all voices idle, tags and ages read as zero through
//   per-voice written bits, voices_in_use = 8 (limited to MAX_VOICES), retrigger off
`timescale 1ns / 1ps
`include "polyphonic_voice_allocator_assert.svh"
module polyphonic_voice_allocator #(
  parameter int MAX_VOICES = 32,
  parameter int AGE_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pva_pkg::ACT_W-1:0]         in_action,
  input  logic signed [pva_pkg::TAG_W-1:0]  in_note_pitch,
  input  logic [pva_pkg::INTENS_W-1:0]      in_note_intensity,
  input  logic [pva_pkg::VOICE_W-1:0]       in_done_voice,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_voice_granted,
  output logic [pva_pkg::VOICE_W-1:0]       out_granted_voice,
  output logic                              out_was_stolen,
  output logic                              out_was_retriggered,
  output logic signed [pva_pkg::TAG_W-1:0]  out_start_pitch,
  output logic [pva_pkg::INTENS_W-1:0]      out_start_intensity,
  output logic [pva_pkg::MASK_W-1:0]        out_stop_mask,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pva_pkg::ADDR_W-1:0]        paddr,
  input  logic [pva_pkg::DATA_W-1:0]        pwdata,
  output logic [pva_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import pva_pkg::*;

  localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VOICES + 1);
  localparam int WORD_W = TAG_W + AGE_BITS;
  localparam logic [NV_W-1:0] NV_MAX   = NV_W'(MAX_VOICES);
  localparam logic [NV_W-1:0] NV_RESET = (MAX_VOICES < 8) ? NV_W'(MAX_VOICES) : NV_W'(8);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [NV_W-1:0]       nv_r, nv_nxt;
  logic                  retrig_r, retrig_nxt;
  logic [MAX_VOICES-1:0] active_r, active_nxt;
  logic [MAX_VOICES-1:0] written_r, written_nxt;
  logic [MAX_VOICES-1:0] in_use_mask;

  logic [ACT_W-1:0]      act_r;
  logic [TAG_W-1:0]      pitch_r;
  logic [INTENS_W-1:0]   intens_r;

  logic [CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  pv_r, pv_nxt;
  logic [VIDX_W-1:0]     pidx_r, pidx_nxt;
  logic                  chosen_valid_r, chosen_valid_nxt;
  logic [VIDX_W-1:0]     chosen_r, chosen_nxt;
  logic                  matched_r, matched_nxt;
  logic [VIDX_W-1:0]     oldest_r, oldest_nxt;
  logic [AGE_BITS-1:0]   max_age_r, max_age_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;

  logic                  res_granted_r, res_granted_nxt;
  logic [VIDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic                  res_stolen_r, res_stolen_nxt;
  logic                  res_retrig_r, res_retrig_nxt;

  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [VOICE_W-1:0]    out_voice_r;
  logic                  out_stolen_r;
  logic                  out_retrig_r;
  logic [TAG_W-1:0]      out_pitch_r;
  logic [INTENS_W-1:0]   out_intens_r;
  logic [MASK_W-1:0]     out_mask_r;

  logic                  in_xfer, cfg_wr, emit_go, act_on;
  logic [CNT_W-1:0]      nv_cnt;
  logic                  ram_we, ram_re;
  logic [VIDX_W-1:0]     ram_waddr, ram_raddr, fin_idx;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  logic [TAG_W-1:0]      rd_tag;
  logic [AGE_BITS-1:0]   rd_age, age_inc;
  logic                  first_proc, last_proc;
  logic [NV_W-1:0]       cfg_nv;
  scan_flags_t           flags;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign nv_cnt   = nv_r[CNT_W-1:0];
  assign act_on   = (act_r == ACT_NOTE_ON);
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign fin_idx  = chosen_valid_r ? chosen_r : oldest_r;
  assign cfg_nv   = (pwdata[NV_W-1:0] > NV_MAX) ? NV_MAX : pwdata[NV_W-1:0];

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_VOICES: prdata = DATA_W'(nv_r);
      REG_RETRIG: prdata = DATA_W'(retrig_r);
      default:    prdata = '0;
    endcase
  end

  // unwritten entries read as the reset value
  assign rd_tag = written_r[pidx_r] ? ram_rdata[WORD_W-1:AGE_BITS] : '0;
  assign rd_age = written_r[pidx_r] ? ram_rdata[AGE_BITS-1:0] : '0;
  assign first_proc = (pidx_r == '0);
  assign last_proc  = pv_r && (CNT_W'(pidx_r) + CNT_W'(1) == nv_cnt);

  pva_scan_unit #(.AGE_BITS(AGE_BITS)) u_scan (
    .tag     (rd_tag),
    .age     (rd_age),
    .pitch   (pitch_r),
    .retrig  (retrig_r),
    .max_age (max_age_r),
    .first   (first_proc),
    .age_inc (age_inc),
    .flags   (flags)
  );

  pva_ram #(.WIDTH(WORD_W), .DEPTH(MAX_VOICES), .AW(VIDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = scan_idx_r[VIDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = pidx_r;
    ram_wdata = {rd_tag, age_inc};
    if (state_r == ST_SCAN) begin
      ram_re = (scan_idx_r < nv_cnt);
      // age write-back for active voices during a note-on walk
      ram_we = pv_r && act_on && active_r[pidx_r];
    end else if (state_r == ST_FINISH && act_on) begin
      ram_we    = 1'b1;
      ram_waddr = fin_idx;
      ram_wdata = {pitch_r, {AGE_BITS{1'b0}}};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VOICES; i++) begin
      in_use_mask[i] = (NV_W'(i) < nv_r);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    nv_nxt           = nv_r;
    retrig_nxt       = retrig_r;
    active_nxt       = active_r;
    written_nxt      = written_r;
    scan_idx_nxt     = scan_idx_r;
    pv_nxt           = 1'b0;
    pidx_nxt         = pidx_r;
    chosen_valid_nxt = chosen_valid_r;
    chosen_nxt       = chosen_r;
    matched_nxt      = matched_r;
    oldest_nxt       = oldest_r;
    max_age_nxt      = max_age_r;
    mask_nxt         = mask_r;
    res_granted_nxt  = res_granted_r;
    res_idx_nxt      = res_idx_r;
    res_stolen_nxt   = res_stolen_r;
    res_retrig_nxt   = res_retrig_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_VOICES) begin
        // voices newly brought into use start idle
        for (int i = 0; i < MAX_VOICES; i++) begin
          if (NV_W'(i) >= nv_r && NV_W'(i) < cfg_nv) begin
            active_nxt[i] = 1'b0;
          end
        end
        nv_nxt = cfg_nv;
      end else begin
        retrig_nxt = pwdata[0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_idx_nxt     = '0;
          chosen_valid_nxt = 1'b0;
          matched_nxt      = 1'b0;
          oldest_nxt       = '0;
          max_age_nxt      = '0;
          mask_nxt         = '0;
          res_granted_nxt  = 1'b0;
          res_idx_nxt      = '0;
          res_stolen_nxt   = 1'b0;
          res_retrig_nxt   = 1'b0;
          state_nxt        = ST_EMIT;
          if ((in_action == ACT_NOTE_ON || in_action == ACT_NOTE_OFF) && nv_r != '0) begin
            state_nxt = ST_SCAN;
          end
          if (in_action == ACT_DONE && ({1'b0, in_done_voice} < NV_MAX)) begin
            active_nxt[in_done_voice[VIDX_W-1:0]] = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_r < nv_cnt) begin
          pv_nxt       = 1'b1;
          pidx_nxt     = scan_idx_r[VIDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (pv_r) begin
          if (act_on) begin
            if (flags.hit) begin
              chosen_nxt       = pidx_r;
              chosen_valid_nxt = 1'b1;
              matched_nxt      = 1'b1;
            end
            if (active_r[pidx_r]) begin
              if (flags.older) begin
                oldest_nxt  = pidx_r;
                max_age_nxt = age_inc;
              end
            end else if (!chosen_valid_r && !flags.hit) begin
              chosen_nxt       = pidx_r;
              chosen_valid_nxt = 1'b1;
            end
          end else if (active_r[pidx_r] && flags.tag_eq) begin
            mask_nxt = mask_r | (MASK_W'(1) << pidx_r);
          end
        end
        if (last_proc) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (act_on) begin
          active_nxt[fin_idx]  = 1'b1;
          written_nxt[fin_idx] = 1'b1;
          res_granted_nxt      = 1'b1;
          res_idx_nxt          = fin_idx;
          res_stolen_nxt       = !chosen_valid_r;
          res_retrig_nxt       = matched_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nv_r        <= NV_RESET;
      retrig_r    <= 1'b0;
      active_r    <= '0;
      written_r   <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nv_r      <= nv_nxt;
      retrig_r  <= retrig_nxt;
      active_r  <= active_nxt;
      written_r <= written_nxt;
      pv_r      <= pv_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r    <= in_action;
      pitch_r  <= in_note_pitch;
      intens_r <= in_note_intensity;
    end
    scan_idx_r     <= scan_idx_nxt;
    pidx_r         <= pidx_nxt;
    chosen_valid_r <= chosen_valid_nxt;
    chosen_r       <= chosen_nxt;
    matched_r      <= matched_nxt;
    oldest_r       <= oldest_nxt;
    max_age_r      <= max_age_nxt;
    mask_r         <= mask_nxt;
    res_granted_r  <= res_granted_nxt;
    res_idx_r      <= res_idx_nxt;
    res_stolen_r   <= res_stolen_nxt;
    res_retrig_r   <= res_retrig_nxt;
    if (emit_go) begin
      out_granted_r <= res_granted_r;
      out_voice_r   <= VOICE_W'(res_idx_r);
      out_stolen_r  <= res_stolen_r;
      out_retrig_r  <= res_retrig_r;
      out_pitch_r   <= res_granted_r ? pitch_r : '0;
      out_intens_r  <= res_granted_r ? intens_r : '0;
      out_mask_r    <= mask_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_voice_granted   = out_granted_r;
  assign out_granted_voice   = out_voice_r;
  assign out_was_stolen      = out_stolen_r;
  assign out_was_retriggered = out_retrig_r;
  assign out_start_pitch     = out_pitch_r;
  assign out_start_intensity = out_intens_r;
  assign out_stop_mask       = out_mask_r;

  `PVA_ASSERT_IMP(a_flags_excl, out_valid_r, !(out_stolen_r && out_retrig_r),
    "steal and retrigger both flagged")
  `PVA_ASSERT_IMP(a_scan_range, pv_r, (CNT_W'(pidx_r) < nv_cnt), "walk beyond voices in use")
  `PVA_ASSERT_IMP(a_steal_full, (state_r == ST_FINISH) && act_on && !chosen_valid_r,
    (&(active_r | ~in_use_mask)), "steal with an idle voice in use")
  `PVA_ASSERT_NXT(a_grant_active, (state_r == ST_FINISH) && act_on,
    active_r[$past(fin_idx)], "granted voice not active")

endmodule

// ----- hdl/pva_ram.sv -----
`timescale 1ns / 1ps
module pva_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pva_scan_unit.sv -----
`timescale 1ns / 1ps
module pva_scan_unit #(
  parameter int AGE_BITS = 16
) (
  input  logic [pva_pkg::TAG_W-1:0] tag,
  input  logic [AGE_BITS-1:0]       age,
  input  logic [pva_pkg::TAG_W-1:0] pitch,
  input  logic                      retrig,
  input  logic [AGE_BITS-1:0]       max_age,
  input  logic                      first,
  output logic [AGE_BITS-1:0]       age_inc,
  output pva_pkg::scan_flags_t      flags
);
  import pva_pkg::*;

  logic tag_eq;

  assign tag_eq  = (tag == pitch);
  // ages stop at all ones
  assign age_inc = (&age) ? age : age + AGE_BITS'(1);

  assign flags.tag_eq = tag_eq;
  assign flags.hit    = retrig && tag_eq;
  assign flags.older  = first || (age_inc > max_age);

endmodule
